// File: hw/rtl/tcep_pkg.sv
// Shared types and constants for the text console escape parser.
`default_nettype none

package tcep_pkg;

  // Screen size defaults in pixels
  localparam int SCREEN_WIDTH_DEF  = 640;
  localparam int SCREEN_HEIGHT_DEF = 528;

  // Width of the unclipped pixel position sums
  localparam int POS_W = 14;

  // Request types
  localparam logic REQ_TEXT   = 1'b0;
  localparam logic REQ_CURSOR = 1'b1;

  // Text byte codes with special meaning
  localparam logic [7:0] BYTE_END    = 8'h00;
  localparam logic [7:0] BYTE_ESC_FG = 8'h01;
  localparam logic [7:0] BYTE_ESC_BG = 8'h02;
  localparam logic [7:0] BYTE_NL     = 8'h0A;
  localparam logic [7:0] BYTE_SPACE  = 8'h20;

  // Number of color bytes after an escape code
  localparam logic [2:0] ESC_BYTES = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_ORIGIN_X  = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y  = 2'd1;
  localparam logic [1:0] CFG_BASE_FORE = 2'd2;
  localparam logic [1:0] CFG_BASE_BACK = 2'd3;

  // Register reset values
  localparam logic [31:0] BASE_FORE_RST = 32'hFFFF_FFFF;
  localparam logic [31:0] BASE_BACK_RST = 32'h0000_0000;

  // Glyph draw command
  typedef struct packed {
    logic [7:0]  char_code;
    logic [9:0]  pixel_x;
    logic [9:0]  pixel_y;
    logic [31:0] fore_rgba;
    logic [31:0] back_rgba;
  } glyph_cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/tcep_parser.sv
// Cursor, escape collector, color overrides and glyph command generation.
`default_nettype none

module tcep_parser
  import tcep_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        accept,
  input  wire logic        req_type,
  input  wire logic [7:0]  byte_value,
  input  wire logic [7:0]  cursor_col,
  input  wire logic [7:0]  cursor_row,
  output logic             cmd_valid,
  output glyph_cmd_t       cmd
);

  localparam logic [POS_W-1:0] SCR_W = POS_W'(SCREEN_WIDTH);
  localparam logic [POS_W-1:0] SCR_H = POS_W'(SCREEN_HEIGHT);

  logic [9:0]  origin_x_r, origin_y_r;
  logic [31:0] base_fore_r, base_back_r;

  logic [7:0]  col_r, col_nxt;
  logic [7:0]  row_r, row_nxt;
  logic [2:0]  esc_left_r, esc_left_nxt;
  logic        esc_back_r, esc_back_nxt;
  logic [23:0] gather_r, gather_nxt;
  logic [31:0] fore_ovr_r, fore_ovr_nxt;
  logic [31:0] back_ovr_r, back_ovr_nxt;
  logic        fore_on_r, fore_on_nxt;
  logic        back_on_r, back_on_nxt;

  logic [POS_W-1:0] px, py;
  logic             on_screen;
  logic             draw;
  logic [31:0]      esc_color;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r  <= '0;
      origin_y_r  <= '0;
      base_fore_r <= BASE_FORE_RST;
      base_back_r <= BASE_BACK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORIGIN_X:  origin_x_r  <= cfg_wdata[9:0];
        CFG_ORIGIN_Y:  origin_y_r  <= cfg_wdata[9:0];
        CFG_BASE_FORE: base_fore_r <= cfg_wdata;
        CFG_BASE_BACK: base_back_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pixel origin of the cell under the cursor (8x16 cells)
  assign px = POS_W'(origin_x_r) + POS_W'({col_r, 3'b000});
  assign py = POS_W'(origin_y_r) + POS_W'({row_r, 4'b0000});
  assign on_screen = (px < SCR_W) && (py < SCR_H);
  assign esc_color = {gather_r, byte_value};

  // Next state for one transaction
  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    esc_left_nxt = esc_left_r;
    esc_back_nxt = esc_back_r;
    gather_nxt   = gather_r;
    fore_ovr_nxt = fore_ovr_r;
    back_ovr_nxt = back_ovr_r;
    fore_on_nxt  = fore_on_r;
    back_on_nxt  = back_on_r;
    draw         = 1'b0;
    if (accept) begin
      if (req_type == REQ_CURSOR) begin
        col_nxt = cursor_col;
        row_nxt = cursor_row;
      end else if (esc_left_r != '0) begin
        // collecting color bytes, taken literally
        esc_left_nxt = esc_left_r - 3'd1;
        if (esc_left_r == 3'd1) begin
          gather_nxt = '0;
          if (esc_back_r) begin
            back_ovr_nxt = esc_color;
            back_on_nxt  = 1'b1;
          end else begin
            fore_ovr_nxt = esc_color;
            fore_on_nxt  = 1'b1;
          end
        end else begin
          gather_nxt = {gather_r[15:0], byte_value};
        end
      end else begin
        unique case (byte_value)
          BYTE_END: begin
            fore_on_nxt  = 1'b0;
            back_on_nxt  = 1'b0;
            fore_ovr_nxt = '0;
            back_ovr_nxt = '0;
          end
          BYTE_ESC_FG, BYTE_ESC_BG: begin
            esc_left_nxt = ESC_BYTES;
            esc_back_nxt = (byte_value == BYTE_ESC_BG);
            gather_nxt   = '0;
          end
          BYTE_NL: begin
            row_nxt = row_r + 8'd1;
            col_nxt = '0;
          end
          BYTE_SPACE: begin
            col_nxt = col_r + 8'd1;
          end
          default: begin
            draw    = on_screen;
            col_nxt = col_r + 8'd1;
          end
        endcase
      end
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      esc_left_r <= '0;
      esc_back_r <= 1'b0;
      gather_r   <= '0;
      fore_ovr_r <= '0;
      back_ovr_r <= '0;
      fore_on_r  <= 1'b0;
      back_on_r  <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      esc_left_r <= esc_left_nxt;
      esc_back_r <= esc_back_nxt;
      gather_r   <= gather_nxt;
      fore_ovr_r <= fore_ovr_nxt;
      back_ovr_r <= back_ovr_nxt;
      fore_on_r  <= fore_on_nxt;
      back_on_r  <= back_on_nxt;
    end
  end

  // Draw command toward the output buffer
  assign cmd_valid     = draw;
  assign cmd.char_code = byte_value;
  assign cmd.pixel_x   = px[9:0];
  assign cmd.pixel_y   = py[9:0];
  assign cmd.fore_rgba = fore_on_r ? fore_ovr_r : base_fore_r;
  assign cmd.back_rgba = back_on_r ? back_ovr_r : base_back_r;

  // Escape counter never exceeds the color byte count
  a_esc_range: assert property (@(posedge clk) disable iff (!rst_n)
    esc_left_r <= ESC_BYTES)
    else $error("escape counter out of range");

  // End of string drops both overrides
  a_end_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && req_type == REQ_TEXT && esc_left_r == 3'd0 && byte_value == BYTE_END)
    |=> (!fore_on_r && !back_on_r))
    else $error("overrides still on after end of string");

endmodule

`default_nettype wire

// File: hw/rtl/tcep_out_buf.sv
// Two-entry output buffer: result register plus skid register.
`default_nettype none

module tcep_out_buf
  import tcep_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire glyph_cmd_t push_cmd,
  output logic            full,
  output logic            out_valid,
  output glyph_cmd_t      out_cmd,
  input  wire logic       out_stall
);

  logic       out_valid_r;
  glyph_cmd_t out_cmd_r;
  logic       skid_valid_r;
  glyph_cmd_t skid_cmd_r;
  logic       pop;

  assign pop = out_valid_r && !out_stall;

  // Control: output register refills from skid first, then from push
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= push;
      end else begin
        out_valid_r  <= push;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_cmd_r <= skid_cmd_r;
        if (push) skid_cmd_r <= push_cmd;
      end else if (push) begin
        out_cmd_r <= push_cmd;
      end
    end else if (push) begin
      skid_cmd_r <= push_cmd;
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_cmd   = out_cmd_r;

  // Skid holds data only behind a full output register
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry without output entry");

  // No transaction is pushed into a full buffer
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && skid_valid_r))
    else $error("push into full output buffer");

endmodule

`default_nettype wire

// File: hw/rtl/text_console_escape_parser_unit.sv
// Text console escape parser: top level.
//
// Input channel (in_*): one text byte or one set-cursor request per
// transaction, accepted when in_valid is high and in_stall low.
// Output channel (out_*): one glyph draw command (character code, cell pixel
// origin, foreground and background color) per on-screen byte other than a special code.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (origin x,
// origin y, base foreground, base background); write only while idle.
// Draw commands are registered in the result register or the skid register.
// Throughput: one transaction per cycle while in_stall is low, set by the
// combinational cursor and escape update followed by the result register.
// Stall: a two-entry output buffer (result register plus skid register)
// absorbs one more command while the receiver stalls; in_stall rises when
// the skid register is occupied and falls once the receiver takes a command.
// Reset (rst_n low, synchronous): cursor at 0,0, no escape in progress,
// overrides off, origin 0,0, foreground all ones, background zero, output
// buffer empty.
`default_nettype none

module text_console_escape_parser_unit
  import tcep_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_req_type,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic [7:0]  in_cursor_col,
  input  wire logic [7:0]  in_cursor_row,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_char_code,
  output logic [9:0]       out_pixel_x,
  output logic [9:0]       out_pixel_y,
  output logic [31:0]      out_fore_rgba,
  output logic [31:0]      out_back_rgba
);

  logic       in_accept;
  logic       cmd_valid;
  glyph_cmd_t cmd;
  logic       buf_full;
  glyph_cmd_t out_cmd;

  assign in_stall  = buf_full;
  assign in_accept = in_valid && !in_stall;

  tcep_parser #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .accept     (in_accept),
    .req_type   (in_req_type),
    .byte_value (in_byte_value),
    .cursor_col (in_cursor_col),
    .cursor_row (in_cursor_row),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd)
  );

  tcep_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_valid),
    .push_cmd  (cmd),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_cmd   (out_cmd),
    .out_stall (out_stall)
  );

  assign out_char_code = out_cmd.char_code;
  assign out_pixel_x   = out_cmd.pixel_x;
  assign out_pixel_y   = out_cmd.pixel_y;
  assign out_fore_rgba = out_cmd.fore_rgba;
  assign out_back_rgba = out_cmd.back_rgba;

endmodule

`default_nettype wire

// File: verif/tcep_check_pkg.sv
// Scoreboard for the text console escape parser: cursor, escape and color prediction.
package tcep_check_pkg;
  import tcep_pkg::*;

  class glyph_scoreboard;
    // Register copies
    bit [9:0]  origin_x;
    bit [9:0]  origin_y;
    bit [31:0] base_fore;
    bit [31:0] base_back;

    // Console state
    bit [7:0]  col_pos;
    bit [7:0]  row_pos;
    bit [2:0]  esc_left;
    bit        esc_back;
    bit [23:0] gather;
    bit [31:0] fore_ovr;
    bit [31:0] back_ovr;
    bit        fore_on;
    bit        back_on;

    glyph_cmd_t expected_glyphs[$];
    int error_count;

    // Everything comes up in its reset state
    function new();
      origin_x    = '0;
      origin_y    = '0;
      base_fore   = BASE_FORE_RST;
      base_back   = BASE_BACK_RST;
      col_pos     = '0;
      row_pos     = '0;
      esc_left    = '0;
      esc_back    = 1'b0;
      gather      = '0;
      fore_ovr    = '0;
      back_ovr    = '0;
      fore_on     = 1'b0;
      back_on     = 1'b0;
      error_count = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] data);
      case (idx)
        CFG_ORIGIN_X:  origin_x = data[9:0];
        CFG_ORIGIN_Y:  origin_y = data[9:0];
        CFG_BASE_FORE: base_fore = data;
        CFG_BASE_BACK: base_back = data;
        default: ;
      endcase
    endfunction

    // Advance the console by one accepted transaction, queue any draw command
    function void note_request(logic req, logic [7:0] code, logic [7:0] col,
                               logic [7:0] row);
      int px;
      int py;
      glyph_cmd_t cmd;
      if (req == REQ_CURSOR) begin
        // cursor load leaves escape and overrides alone
        col_pos = col;
        row_pos = row;
        return;
      end
      if (esc_left != 0) begin
        // every byte is color data while collecting, first byte on top
        if (esc_left == 3'd1) begin
          if (esc_back) begin
            back_ovr = {gather, code};
            back_on  = 1'b1;
          end else begin
            fore_ovr = {gather, code};
            fore_on  = 1'b1;
          end
          gather = '0;
        end else begin
          gather = {gather[15:0], code};
        end
        esc_left--;
        return;
      end
      case (code)
        BYTE_END: begin
          fore_on  = 1'b0;
          back_on  = 1'b0;
          fore_ovr = '0;
          back_ovr = '0;
        end
        BYTE_ESC_FG, BYTE_ESC_BG: begin
          esc_left = ESC_BYTES;
          esc_back = (code == BYTE_ESC_BG);
          gather   = '0;
        end
        BYTE_NL: begin
          row_pos++;
          col_pos = '0;
        end
        BYTE_SPACE: col_pos++;
        default: begin
          // 8x16 cells; off-screen glyphs draw nothing but still advance
          px = int'(origin_x) + (int'(col_pos) << 3);
          py = int'(origin_y) + (int'(row_pos) << 4);
          if (px < SCREEN_WIDTH_DEF && py < SCREEN_HEIGHT_DEF) begin
            cmd.char_code = code;
            cmd.pixel_x   = px[9:0];
            cmd.pixel_y   = py[9:0];
            cmd.fore_rgba = fore_on ? fore_ovr : base_fore;
            cmd.back_rgba = back_on ? back_ovr : base_back;
            expected_glyphs.push_back(cmd);
          end
          col_pos++;
        end
      endcase
    endfunction

    task report_mismatch(string note);
      if (error_count < 50) $display("mismatch: %s", note);
      error_count++;
    endtask

    // Compare one draw command against the oldest expected one
    task check_glyph(glyph_cmd_t got);
      glyph_cmd_t want;
      if (expected_glyphs.size() == 0) begin
        report_mismatch($sformatf("unexpected glyph %02h at %0d,%0d", got.char_code,
                                  got.pixel_x, got.pixel_y));
        return;
      end
      want = expected_glyphs.pop_front();
      if (got.char_code !== want.char_code)
        report_mismatch($sformatf("char_code %02h, want %02h", got.char_code,
                                  want.char_code));
      if (got.pixel_x !== want.pixel_x)
        report_mismatch($sformatf("pixel_x %0d, want %0d", got.pixel_x, want.pixel_x));
      if (got.pixel_y !== want.pixel_y)
        report_mismatch($sformatf("pixel_y %0d, want %0d", got.pixel_y, want.pixel_y));
      if (got.fore_rgba !== want.fore_rgba)
        report_mismatch($sformatf("fore_rgba %08h, want %08h", got.fore_rgba,
                                  want.fore_rgba));
      if (got.back_rgba !== want.back_rgba)
        report_mismatch($sformatf("back_rgba %08h, want %08h", got.back_rgba,
                                  want.back_rgba));
    endtask
  endclass

endpackage

// File: verif/tb_text_console_escape_parser_unit.sv
// Testbench top for the text console escape parser: stimulus, handshakes and end of run.
module tb_text_console_escape_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tcep_pkg::*;
  import tcep_check_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 250;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        cfg_we        = 1'b0;
  logic [1:0]  cfg_index     = CFG_ORIGIN_X;
  logic [31:0] cfg_wdata     = '0;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic        in_req_type   = REQ_TEXT;
  logic [7:0]  in_byte_value = '0;
  logic [7:0]  in_cursor_col = '0;
  logic [7:0]  in_cursor_row = '0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [7:0]  out_char_code;
  logic [9:0]  out_pixel_x;
  logic [9:0]  out_pixel_y;
  logic [31:0] out_fore_rgba;
  logic [31:0] out_back_rgba;

  int cycle_count = 0;
  int sent_count  = 0;
  int gap_pct     = 0;
  int stall_pct   = 0;

  glyph_scoreboard sb;

  text_console_escape_parser_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_byte_value (in_byte_value),
    .in_cursor_col (in_cursor_col),
    .in_cursor_row (in_cursor_row),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_code (out_char_code),
    .out_pixel_x   (out_pixel_x),
    .out_pixel_y   (out_pixel_y),
    .out_fore_rgba (out_fore_rgba),
    .out_back_rgba (out_back_rgba)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Watch both channels; values sampled are the ones before the edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_request(in_req_type, in_byte_value, in_cursor_col, in_cursor_row);
    if (rst_n && out_valid && !out_stall)
      sb.check_glyph({out_char_code, out_pixel_x, out_pixel_y, out_fore_rgba,
                      out_back_rgba});
  end

  // Receiver stalls in bursts, each begun with a chance of stall_pct percent
  initial begin : receiver_stall
    forever begin
      @(posedge clk);
      if (stall_pct > 0 && $urandom_range(1, 100) <= stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // One transaction on the input channel, with an optional idle burst first
  task automatic send_item(logic req, logic [7:0] code, logic [7:0] col, logic [7:0] row);
    if (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_byte_value <= code;
    in_cursor_col <= col;
    in_cursor_row <= row;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  // Unused fields carry random junk so that they are seen to be ignored
  task automatic send_text(logic [7:0] code);
    send_item(REQ_TEXT, code, 8'($urandom()), 8'($urandom()));
  endtask

  task automatic send_cursor(logic [7:0] col, logic [7:0] row);
    send_item(REQ_CURSOR, 8'($urandom()), col, row);
  endtask

  task automatic send_escape(logic is_back, logic [31:0] color);
    send_text(is_back ? BYTE_ESC_BG : BYTE_ESC_FG);
    send_text(color[31:24]);
    send_text(color[23:16]);
    send_text(color[15:8]);
    send_text(color[7:0]);
  endtask

  // Sender holds off until every expected draw command has come out
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_glyphs.size() != 0);
  endtask

  // Write all four registers; origin data carries junk above bit 9
  task automatic write_registers(logic [9:0] ox, logic [9:0] oy, logic [31:0] fore,
                                 logic [31:0] back);
    logic [31:0] data [4];
    data[CFG_ORIGIN_X]  = ($urandom() & 32'hFFFF_FC00) | 32'(ox);
    data[CFG_ORIGIN_Y]  = ($urandom() & 32'hFFFF_FC00) | 32'(oy);
    data[CFG_BASE_FORE] = fore;
    data[CFG_BASE_BACK] = back;
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 2'(i);
      cfg_wdata <= data[i];
      sb.set_register(2'(i), data[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed strings; the rest is noise and cut-off escapes
  task automatic send_random_string();
    logic [7:0] c;
    if ($urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 4) == 0)
        send_cursor(8'($urandom()), 8'($urandom()));
      else
        send_cursor(8'($urandom_range(0, 85)), 8'($urandom_range(0, 36)));
      if ($urandom_range(0, 1) == 1) send_escape(1'b0, $urandom());
      if ($urandom_range(0, 2) == 0) send_escape(1'b1, $urandom());
      repeat ($urandom_range(1, 24)) begin
        case ($urandom_range(0, 11))
          0: c = BYTE_SPACE;
          1: c = BYTE_NL;
          2, 3: c = 8'($urandom_range(8'h80, 8'hFF));
          default: c = 8'($urandom_range(8'h21, 8'h7E));
        endcase
        if ($urandom_range(0, 19) == 0) send_escape(1'($urandom()), $urandom());
        send_text(c);
      end
      send_text(BYTE_END);
    end else begin
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(0, 7))
          0: send_cursor(8'($urandom()), 8'($urandom()));
          1: begin
            // escape broken by a cursor load; collection resumes afterwards
            send_text($urandom_range(0, 1) == 1 ? BYTE_ESC_BG : BYTE_ESC_FG);
            repeat ($urandom_range(0, 3)) send_text(8'($urandom()));
            send_cursor(8'($urandom_range(0, 85)), 8'($urandom_range(0, 36)));
          end
          default: send_text(8'($urandom()));
        endcase
      end
    end
  endtask

  initial begin : main
    int phase_goal;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed checks on reset registers
    send_text(8'h41);
    send_text(BYTE_SPACE);
    send_text(8'hFF);
    send_text(BYTE_NL);
    // foreground escape with zero and control codes as data
    send_escape(1'b0, 32'h0001_0A20);
    // background escape interrupted by a cursor load at the last on-screen cell
    send_text(BYTE_ESC_BG);
    send_text(8'hFF);
    send_cursor(8'd79, 8'd32);
    send_text(BYTE_END);
    send_text(BYTE_ESC_BG);
    send_text(BYTE_END);
    send_text(8'h42);
    // far corner is off screen; column and row then wrap
    send_cursor(8'hFF, 8'hFF);
    send_text(8'h43);
    send_text(BYTE_NL);
    send_text(8'h44);
    // end of string drops both overrides
    send_text(BYTE_END);
    send_text(8'h80);
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    // Random phases, each with its own register setting
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: write_registers(10'd1023, 10'd1023, '0, 32'hFFFF_FFFF);
        1: write_registers(10'd632, 10'd512, $urandom(), $urandom());
        2: write_registers('0, '0, $urandom(), $urandom());
        PHASES - 1: write_registers('0, '0, BASE_FORE_RST, BASE_BACK_RST);
        default: begin
          if ($urandom_range(0, 3) == 0)
            write_registers(10'($urandom()), 10'($urandom()), $urandom(), $urandom());
          else
            write_registers(10'($urandom_range(0, 64)), 10'($urandom_range(0, 64)),
                            $urandom(), $urandom());
        end
      endcase
      if (phase == PHASES - 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = (phase % 3 == 0) ? 0 : int'($urandom_range(5, 40));
        stall_pct = (phase % 3 == 1) ? 0 : int'($urandom_range(5, 40));
      end
      phase_goal = sent_count + PHASE_ITEMS;
      while (sent_count < phase_goal) begin
        send_random_string();
        if (phase == 2) wait_for_drain();
      end
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clk);
    end

    if (sb.expected_glyphs.size() != 0)
      sb.report_mismatch($sformatf("%0d draw commands never came",
                                   sb.expected_glyphs.size()));
    if (sb.error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/tcep_pkg.sv
hw/rtl/tcep_parser.sv
hw/rtl/tcep_out_buf.sv
hw/rtl/text_console_escape_parser_unit.sv
verif/tcep_check_pkg.sv
verif/tb_text_console_escape_parser_unit.sv
